### rtl/masked_table_weighted_sum_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the masked table weighted sum block.
// Each macro expects signals named clk and rst_n in the enclosing scope.
// ----------------------------------------------------------------------------
`ifndef MASKED_TABLE_WEIGHTED_SUM_MACROS_SVH
`define MASKED_TABLE_WEIGHTED_SUM_MACROS_SVH

`ifndef NO_ASSERTIONS

`define MTWS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define MTWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MTWS_ASSERT_SAME(lbl, ante, cons, msg)

`define MTWS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### rtl/mtws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtws_pkg
// Types and constants shared by the masked table weighted sum block.
// ----------------------------------------------------------------------------
package mtws_pkg;

  localparam int NUM_SAMPLES    = 8;
  localparam int COEF_FRAC_BITS = 14;

  localparam int ROW_STRIDE = 8;
  localparam int LANE_W     = $clog2(ROW_STRIDE);
  localparam int IDX_W      = 11;
  localparam int ROW_W      = IDX_W - LANE_W;
  localparam int ROW_DEPTH  = 1 << ROW_W;
  localparam int DATA_W     = 16;
  localparam int MIN_GOOD_W = 4;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int SUM_W      = PROD_W + LANE_W;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = DATA_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_GOOD   = 1'b0,
    REG_FILL_VALUE = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_PIXEL = 1'b1
  } opcode_t;

  typedef struct packed {
    logic                     opcode;
    logic [IDX_W-1:0]         table_index;
    logic signed [DATA_W-1:0] table_word;
    logic [ROW_STRIDE-1:0]    missing_bits;
    logic signed [DATA_W-1:0] sample_0;
    logic signed [DATA_W-1:0] sample_1;
    logic signed [DATA_W-1:0] sample_2;
    logic signed [DATA_W-1:0] sample_3;
    logic signed [DATA_W-1:0] sample_4;
    logic signed [DATA_W-1:0] sample_5;
    logic signed [DATA_W-1:0] sample_6;
    logic signed [DATA_W-1:0] sample_7;
  } in_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_value;
    logic                     used_fill;
    logic                     saturated;
  } out_rsp_t;

endpackage

### rtl/mtws_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtws_in_if / mtws_out_if
// Valid/ready channels carrying pixel and load requests in, and results out.
// ----------------------------------------------------------------------------
interface mtws_in_if;
  import mtws_pkg::*;

  logic    valid;
  logic    ready;
  in_req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mtws_out_if;
  import mtws_pkg::*;

  logic     valid;
  logic     ready;
  out_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/mtws_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtws_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mtws_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/masked_table_weighted_sum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_table_weighted_sum
// Per-pixel weighted sum of frame samples with coefficients chosen by the
// missing-sample mask, with fill value when too few samples are good.
// ----------------------------------------------------------------------------
//   channel   dir  handshake            payload
//   in_req    in   valid / ready        opcode, table_index, table_word,
//                                       missing_bits, sample_0..sample_7
//   out_rsp   out  valid / ready        out_value, used_fill, saturated
//   cfg       in   cfg_we               cfg_index, cfg_wdata
//
// One request is taken per cycle unless a stall has backed up to the input.
// A pixel result is registered through coefficient bank read, multiply, two
// adder levels with shift, saturation and fill select into the output register.
// Load requests write one coefficient bank and produce no result.
// Synchronous reset clears the pipeline valid bits and both registers; the
// coefficient banks are not cleared. A stalled output backs up stage by stage.
// ----------------------------------------------------------------------------
`include "masked_table_weighted_sum_macros.svh"

module masked_table_weighted_sum (
  input  logic                             clk,
  input  logic                             rst_n,
  mtws_in_if.sink                          in_req,
  mtws_out_if.source                       out_rsp,
  input  logic                             cfg_we,
  input  logic [mtws_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mtws_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import mtws_pkg::*;

  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(-32768);

  logic [MIN_GOOD_W-1:0]     min_good_r;
  logic signed [DATA_W-1:0]  fill_value_r;

  logic                      v1_r;
  logic                      v2_r;
  logic                      v3_r;
  logic                      out_valid_r;
  logic                      rdy1;
  logic                      rdy2;
  logic                      rdy3;
  logic                      rdy4;

  logic                      acc;
  logic                      acc_load;
  logic                      acc_pixel;
  logic [ROW_W-1:0]          row_addr;
  logic [ROW_STRIDE-1:0]     good_in;
  logic [MIN_GOOD_W-1:0]     ngood_in;
  logic signed [DATA_W-1:0]  sample_in [ROW_STRIDE];

  logic signed [DATA_W-1:0]  coef [ROW_STRIDE];
  logic signed [DATA_W-1:0]  s1_sample_r [ROW_STRIDE];
  logic [ROW_STRIDE-1:0]     s1_good_r;
  logic [MIN_GOOD_W-1:0]     s1_ngood_r;

  logic signed [PROD_W-1:0]  prod_nxt [ROW_STRIDE];
  logic signed [PROD_W-1:0]  s2_prod_r [ROW_STRIDE];
  logic [MIN_GOOD_W-1:0]     s2_ngood_r;

  logic signed [PROD_W+1:0]  half_lo_nxt;
  logic signed [PROD_W+1:0]  half_hi_nxt;
  logic signed [PROD_W+1:0]  s3_lo_r;
  logic signed [PROD_W+1:0]  s3_hi_r;
  logic [MIN_GOOD_W-1:0]     s3_ngood_r;

  logic signed [SUM_W-1:0]   total;
  logic signed [SUM_W-1:0]   shifted;
  out_rsp_t                  out_nxt;
  out_rsp_t                  out_r;

  assign rdy4 = !out_valid_r || out_rsp.ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign in_req.ready = rdy1;
  assign acc          = in_req.valid && rdy1;
  assign acc_load     = acc && (in_req.data.opcode == OP_LOAD);
  assign acc_pixel    = acc && (in_req.data.opcode == OP_PIXEL);

  assign sample_in[0] = in_req.data.sample_0;
  assign sample_in[1] = in_req.data.sample_1;
  assign sample_in[2] = in_req.data.sample_2;
  assign sample_in[3] = in_req.data.sample_3;
  assign sample_in[4] = in_req.data.sample_4;
  assign sample_in[5] = in_req.data.sample_5;
  assign sample_in[6] = in_req.data.sample_6;
  assign sample_in[7] = in_req.data.sample_7;

  always_comb begin
    row_addr = '0;
    good_in  = '0;
    ngood_in = '0;
    for (int k = 0; k < NUM_SAMPLES; k++) begin
      row_addr[k] = in_req.data.missing_bits[k];
      good_in[k]  = !in_req.data.missing_bits[k];
      ngood_in    = ngood_in + MIN_GOOD_W'(good_in[k]);
    end
  end

  for (genvar k = 0; k < ROW_STRIDE; k++) begin : g_lane
    if (k < NUM_SAMPLES) begin : g_bank
      mtws_ram #(
        .WIDTH (DATA_W),
        .DEPTH (ROW_DEPTH)
      ) u_bank (
        .clk   (clk),
        .we    (acc_load && (in_req.data.table_index[LANE_W-1:0] == LANE_W'(k))),
        .waddr (in_req.data.table_index[IDX_W-1:LANE_W]),
        .wdata (in_req.data.table_word),
        .re    (acc_pixel),
        .raddr (row_addr),
        .rdata (coef[k])
      );
    end else begin : g_pad
      assign coef[k] = '0;
    end

    assign prod_nxt[k] = s1_good_r[k] ? PROD_W'(coef[k] * s1_sample_r[k]) : '0;
  end

  assign half_lo_nxt = (PROD_W+2)'(s2_prod_r[0]) + (PROD_W+2)'(s2_prod_r[1])
                     + (PROD_W+2)'(s2_prod_r[2]) + (PROD_W+2)'(s2_prod_r[3]);
  assign half_hi_nxt = (PROD_W+2)'(s2_prod_r[4]) + (PROD_W+2)'(s2_prod_r[5])
                     + (PROD_W+2)'(s2_prod_r[6]) + (PROD_W+2)'(s2_prod_r[7]);

  assign total   = SUM_W'(s3_lo_r) + SUM_W'(s3_hi_r);
  assign shifted = total >>> COEF_FRAC_BITS;

  always_comb begin
    out_nxt.used_fill = 1'b0;
    out_nxt.saturated = 1'b0;
    out_nxt.out_value = shifted[DATA_W-1:0];
    if (s3_ngood_r < min_good_r) begin
      out_nxt.used_fill = 1'b1;
      out_nxt.out_value = fill_value_r;
    end else if (shifted > SAT_MAX) begin
      out_nxt.saturated = 1'b1;
      out_nxt.out_value = SAT_MAX[DATA_W-1:0];
    end else if (shifted < SAT_MIN) begin
      out_nxt.saturated = 1'b1;
      out_nxt.out_value = SAT_MIN[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_good_r   <= '0;
      fill_value_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MIN_GOOD:   min_good_r   <= cfg_wdata[MIN_GOOD_W-1:0];
        REG_FILL_VALUE: fill_value_r <= cfg_wdata[DATA_W-1:0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= acc_pixel;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy4) begin
        out_valid_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_pixel) begin
      s1_sample_r <= sample_in;
      s1_good_r   <= good_in;
      s1_ngood_r  <= ngood_in;
    end
    if (rdy2) begin
      s2_prod_r  <= prod_nxt;
      s2_ngood_r <= s1_ngood_r;
    end
    if (rdy3) begin
      s3_lo_r    <= half_lo_nxt;
      s3_hi_r    <= half_hi_nxt;
      s3_ngood_r <= s2_ngood_r;
    end
    if (rdy4) begin
      out_r <= out_nxt;
    end
  end

  assign out_rsp.valid = out_valid_r;
  assign out_rsp.data  = out_r;

  `MTWS_ASSERT_NEXT(a_pixel_enters, acc_pixel, v1_r, "accepted pixel did not enter stage one")
  `MTWS_ASSERT_NEXT(a_load_no_result, acc_load, !v1_r, "load request entered the pixel pipeline")
  `MTWS_ASSERT_SAME(a_stall_needs_full, !in_req.ready, v1_r && v2_r && v3_r && out_valid_r, "input stalled with a bubble in the pipeline")
  `MTWS_ASSERT_SAME(a_fill_not_sat, out_valid_r && out_r.used_fill, !out_r.saturated, "fill result flagged as saturated")
  `MTWS_ASSERT_SAME(a_sat_extreme, out_valid_r && out_r.saturated, (out_r.out_value == SAT_MAX[DATA_W-1:0]) || (out_r.out_value == SAT_MIN[DATA_W-1:0]), "saturated result not at a range limit")

endmodule
